// ===== hw/rtl/sld_pkg.sv =====
// Shared types and constants for the sync-word length-prefixed deframer.
// Used by sld_parser, sld_outbuf and sync_length_frame_deframer; no dependencies.
`timescale 1ns / 1ps

package sld_pkg;

    // Width kept of the received payload length (8 to 24)
    localparam int LenBits = 24;

    localparam logic [7:0]  SyncHi  = 8'hBE;
    localparam logic [7:0]  SyncLo  = 8'hEF;
    localparam logic [15:0] SkipMax = 16'hFFFF;

    // Header parse phase, one-hot
    typedef enum logic [6:0] {
        PH_HUNT1 = 7'b000_0001,
        PH_HUNT2 = 7'b000_0010,
        PH_SEQ   = 7'b000_0100,
        PH_LEN0  = 7'b000_1000,
        PH_LEN1  = 7'b001_0000,
        PH_LEN2  = 7'b010_0000,
        PH_DATA  = 7'b100_0000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_start;
        logic        frame_end;
        logic        empty_frame;
        logic        seq_gap;
        logic [7:0]  frame_seq;
        logic [15:0] skipped_bytes;
    } result_t;

endpackage

// ===== hw/rtl/sld_parser.sv =====
// Byte-at-a-time header parser and payload pass-through for the deframer.
// Depends on sld_pkg for the phase type, the sync constants and result_t.
`timescale 1ns / 1ps

module sld_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output sld_pkg::result_t   res
);

    sld_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                  expected_seq_reg, expected_seq_next;
    logic [7:0]                  current_seq_reg, current_seq_next;
    logic                        gap_seen_reg, gap_seen_next;
    logic [15:0]                 len_hi_reg, len_hi_next;
    logic [sld_pkg::LenBits-1:0] remaining_reg, remaining_next;
    logic [15:0]                 skip_reg, skip_next;
    logic                        first_reg, first_next;

    logic [1:0]                  skip_add;
    logic [16:0]                 skip_sum;
    logic [23:0]                 len_full;
    logic [sld_pkg::LenBits-1:0] len_kept;
    logic                        last_byte;

    // Saturating hunt skip count
    assign skip_sum = {1'b0, skip_reg} + {15'd0, skip_add};

    // Assemble the big-endian length and keep its low bits
    assign len_full  = {len_hi_reg, rx_byte};
    assign len_kept  = len_full[sld_pkg::LenBits-1:0];
    assign last_byte = (remaining_reg == sld_pkg::LenBits'(1));

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        expected_seq_next = expected_seq_reg;
        current_seq_next  = current_seq_reg;
        gap_seen_next     = gap_seen_reg;
        len_hi_next       = len_hi_reg;
        remaining_next    = remaining_reg;
        skip_next         = skip_reg;
        first_next        = first_reg;
        skip_add          = 2'd0;
        res_valid         = 1'b0;

        res.payload_byte  = 8'd0;
        res.frame_start   = 1'b0;
        res.frame_end     = 1'b0;
        res.empty_frame   = 1'b0;
        res.seq_gap       = gap_seen_reg;
        res.frame_seq     = current_seq_reg;
        res.skipped_bytes = skip_reg;

        unique case (phase_reg)
            sld_pkg::PH_HUNT2:
            begin
                if (rx_byte == sld_pkg::SyncLo)
                begin
                    phase_next = sld_pkg::PH_SEQ;
                end
                else if (rx_byte == sld_pkg::SyncHi)
                begin
                    skip_add = 2'd1;
                end
                else
                begin
                    skip_add   = 2'd2;
                    phase_next = sld_pkg::PH_HUNT1;
                end
            end
            sld_pkg::PH_SEQ:
            begin
                current_seq_next = rx_byte;
                if (expected_seq_reg < rx_byte)
                begin
                    gap_seen_next     = 1'b1;
                    expected_seq_next = rx_byte;
                end
                else
                begin
                    gap_seen_next = 1'b0;
                end
                phase_next = sld_pkg::PH_LEN0;
            end
            sld_pkg::PH_LEN0:
            begin
                len_hi_next = {rx_byte, 8'd0};
                phase_next  = sld_pkg::PH_LEN1;
            end
            sld_pkg::PH_LEN1:
            begin
                len_hi_next = {len_hi_reg[15:8], rx_byte};
                phase_next  = sld_pkg::PH_LEN2;
            end
            sld_pkg::PH_LEN2:
            begin
                expected_seq_next = expected_seq_reg + 8'd1;
                remaining_next    = len_kept;
                if (len_kept == '0)
                begin
                    // Empty frame: one marker result
                    res_valid       = 1'b1;
                    res.frame_start = 1'b1;
                    res.frame_end   = 1'b1;
                    res.empty_frame = 1'b1;
                    skip_next       = 16'd0;
                    first_next      = 1'b0;
                    phase_next      = sld_pkg::PH_HUNT1;
                end
                else
                begin
                    first_next = 1'b1;
                    phase_next = sld_pkg::PH_DATA;
                end
            end
            sld_pkg::PH_DATA:
            begin
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.frame_start  = first_reg;
                res.frame_end    = last_byte;
                first_next       = 1'b0;
                remaining_next   = remaining_reg - sld_pkg::LenBits'(1);
                if (last_byte)
                begin
                    skip_next  = 16'd0;
                    phase_next = sld_pkg::PH_HUNT1;
                end
            end
            default:
            begin
                // Hunting the first sync byte; stray codes land here too
                if (rx_byte == sld_pkg::SyncHi)
                begin
                    phase_next = sld_pkg::PH_HUNT2;
                end
                else
                begin
                    skip_add   = 2'd1;
                    phase_next = sld_pkg::PH_HUNT1;
                end
            end
        endcase

        if (skip_add != 2'd0)
        begin
            skip_next = skip_sum[16] ? sld_pkg::SkipMax : skip_sum[15:0];
        end

        if (!accept)
        begin
            res_valid = 1'b0;
        end
    end

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sld_pkg::PH_HUNT1;
            expected_seq_reg <= 8'd0;
            current_seq_reg  <= 8'd0;
            gap_seen_reg     <= 1'b0;
            len_hi_reg       <= 16'd0;
            remaining_reg    <= '0;
            skip_reg         <= 16'd0;
            first_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            expected_seq_reg <= expected_seq_next;
            current_seq_reg  <= current_seq_next;
            gap_seen_reg     <= gap_seen_next;
            len_hi_reg       <= len_hi_next;
            remaining_reg    <= remaining_next;
            skip_reg         <= skip_next;
            first_reg        <= first_next;
        end
    end

endmodule

// ===== hw/rtl/sld_outbuf.sv =====
// Two-entry output buffer: result register plus skid register.
// Depends on sld_pkg for result_t.
`timescale 1ns / 1ps

module sld_outbuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sld_pkg::result_t push_data,
    input  logic             out_ready,
    output logic             out_valid,
    output sld_pkg::result_t out_data,
    output logic             space
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sld_pkg::result_t main_reg, main_next;
    sld_pkg::result_t skid_reg, skid_next;

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    // New request only while the skid slot is free
    assign space     = !skid_valid_reg;

    // Move results forward: skid first, then the new request
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hw/rtl/sync_length_frame_deframer.sv =====
// Top level of the sync-word length-prefixed deframer.
// Depends on sld_pkg, sld_parser and sld_outbuf.
`timescale 1ns / 1ps

// Takes one received byte per cycle while in_ready is high and splits the stream into
// frames: it hunts for the 0xBE 0xEF sync word (counting skipped bytes, saturating at
// 65535), reads a sequence byte and a 24-bit big-endian length, then passes each payload
// byte out with start and end marks; a zero-length frame gives a single empty-frame
// result. Header bytes give no result. Results sit in a two-entry buffer: each one is
// registered in the result register, or in the skid register while the result register
// is held, so in_ready falls only when both entries are full, and throughput is one
// byte per cycle for as long as out_ready stays high.

module sync_length_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        frame_start,
    output logic        frame_end,
    output logic        empty_frame,
    output logic        seq_gap,
    output logic [7:0]  frame_seq,
    output logic [15:0] skipped_bytes
);

    logic             accept;
    logic             res_valid;
    sld_pkg::result_t res;
    sld_pkg::result_t out_data;
    logic             space;

    assign in_ready = space;
    assign accept   = in_valid && space;

    sld_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sld_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .space     (space)
    );

    // Unpack the result onto the ports
    assign payload_byte  = out_data.payload_byte;
    assign frame_start   = out_data.frame_start;
    assign frame_end     = out_data.frame_end;
    assign empty_frame   = out_data.empty_frame;
    assign seq_gap       = out_data.seq_gap;
    assign frame_seq     = out_data.frame_seq;
    assign skipped_bytes = out_data.skipped_bytes;

endmodule
